@@ hdl/bcb_pkg.sv @@
`default_nettype none

package bcb_pkg;

  // Default fraction width of the fixed-point values.
  localparam int FRAC_BITS_DEF = 16;
  // Samples are clamped to this count; the count register is 7 bits wide.
  localparam int MAX_SAMPLES   = 64;
  localparam int CNT_W         = 7;
  localparam int TOL_W         = 16;
  // Result queue depth; the back end issues against credits for it.
  localparam int OUT_DEPTH     = 8;
  localparam int JOB_DEPTH     = 2;

  localparam logic [1:0] PCASE_ACD   = 2'd0;
  localparam logic [1:0] PCASE_DCA   = 2'd1;
  localparam logic [1:0] PCASE_CONST = 2'd2;

  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_TIME_TOL     = 1'b1;

  localparam logic signed [63:0] S32_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN64 = -64'sh0000_0000_8000_0000;

  typedef enum logic [1:0] {
    MODE_FAIL,
    MODE_HOLD,
    MODE_CONST,
    MODE_PROFILE
  } bcb_mode_t;

  typedef enum logic [1:0] {
    K_PRE1,
    K_PRE2,
    K_SAMPLE
  } bcb_kind_t;

  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] end_pos;
    logic [30:0]        switch_time_one;
    logic [30:0]        switch_time_two;
    logic signed [31:0] duration;
    logic [1:0]         profile_case;
    logic [30:0]        accel_limit;
    logic [30:0]        decel_limit;
    logic [31:0]        time_offset;
  } bcb_in_t;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               failed;
    logic               last;
  } bcb_out_t;

  // One classified segment, handed from the front end to the back end.
  typedef struct packed {
    bcb_mode_t          mode;
    logic signed [31:0] p0;
    logic signed [31:0] v0;
    logic [30:0]        t1;
    logic [30:0]        t2;
    logic signed [31:0] dur;
    logic signed [31:0] u1;
    logic signed [31:0] u3;
    logic signed [31:0] vconst;
    logic [31:0]        dt;
    logic [31:0]        offset;
    logic [CNT_W-1:0]   n;
  } bcb_job_t;

  typedef struct packed {
    bcb_kind_t   kind;
    logic [31:0] stime;
    logic        last;
    logic        failed;
  } bcb_meta_t;

  // Operands of one kinematic evaluation: base position, base velocity,
  // acceleration and elapsed time.
  typedef struct packed {
    logic signed [31:0] pb;
    logic signed [31:0] vb;
    logic signed [31:0] u;
    logic signed [31:0] tau;
    bcb_meta_t          meta;
  } bcb_evin_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > S32_MAX64) begin
      return 32'sh7FFF_FFFF;
    end else if (x < S32_MIN64) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/bcb_fifo.sv @@
`default_nettype none

module bcb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bcb_div.sv @@
`default_nettype none

module bcb_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_new;

  // One quotient bit per cycle, restoring form.
  assign rem_sh  = {rem_r, acc_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_new = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  assign done    = done_r;
  assign quo     = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CW'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= CW'(NW);
    end else if (busy_r) begin
      acc_r <= {acc_r[NW-2:0], ge};
      rem_r <= rem_new[DW-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bcb_front.sv @@
`default_nettype none

module bcb_front import bcb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bcb_in_t          in_data,
  output logic                  full,
  input  wire logic [CNT_W-1:0] sample_count,
  input  wire logic [TOL_W-1:0] time_tol,
  output logic                  job_push,
  output bcb_job_t              job_data,
  input  wire logic             job_full
);

  localparam int VNW = 33 + FRAC_BITS;

  typedef enum logic [1:0] {F_IDLE, F_START, F_DIV, F_PUSH} fstate_t;

  fstate_t            state_r;
  logic               ib_valid_r;
  bcb_in_t            ib_r;
  bcb_in_t            seg_r;
  logic               hold_r;
  logic               gt_tol_r;
  logic [CNT_W-1:0]   n_r;
  bcb_job_t           job_r;
  bcb_job_t           job_nxt;

  logic [CNT_W-1:0]   n_clamp;
  logic               fail_now;
  logic signed [31:0] tol_s;
  logic signed [32:0] diff;
  logic               neg;
  logic [32:0]        mag;
  logic [VNW-1:0]     v_num;
  logic [VNW-1:0]     v_quo;
  logic [30:0]        dt_quo;
  logic               dt_done;
  logic               v_done;
  logic               div_start;
  logic               big;
  logic signed [31:0] vsat;
  logic signed [31:0] u_acc;
  logic signed [31:0] u_dec;

  assign full     = ib_valid_r;
  assign job_push = (state_r == F_PUSH) && !job_full;
  assign job_data = job_r;

  assign n_clamp  = (int'(sample_count) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : sample_count;
  assign fail_now = (n_clamp < CNT_W'(2)) || seg_r.duration[31];
  assign tol_s    = $signed({16'b0, time_tol});

  // Constant-velocity case: divide the magnitude of the travel, fix the sign after.
  assign diff  = $signed({seg_r.end_pos[31], seg_r.end_pos})
               - $signed({seg_r.start_pos[31], seg_r.start_pos});
  assign neg   = diff[32];
  assign mag   = neg ? 33'(-diff) : 33'(diff);
  assign v_num = {mag, {FRAC_BITS{1'b0}}};

  assign div_start = (state_r == F_START) && !fail_now;

  bcb_div #(.NW(31), .DW(CNT_W)) u_dt_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (seg_r.duration[30:0]),
    .den   (n_clamp - CNT_W'(1)),
    .done  (dt_done),
    .quo   (dt_quo)
  );

  bcb_div #(.NW(VNW), .DW(31)) u_v_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (v_num),
    .den   (seg_r.duration[30:0]),
    .done  (v_done),
    .quo   (v_quo)
  );

  assign big   = |v_quo[VNW-1:31];
  assign vsat  = neg ? (big ? 32'sh8000_0000 : -$signed(v_quo[31:0]))
                     : (big ? 32'sh7FFF_FFFF : $signed(v_quo[31:0]));
  assign u_acc = $signed({1'b0, seg_r.accel_limit});
  assign u_dec = -$signed({1'b0, seg_r.decel_limit});

  always_comb begin
    job_nxt        = '0;
    job_nxt.mode   = hold_r ? MODE_HOLD
                   : (seg_r.profile_case == PCASE_CONST) ? MODE_CONST : MODE_PROFILE;
    job_nxt.p0     = seg_r.start_pos;
    job_nxt.v0     = seg_r.start_vel;
    job_nxt.t1     = seg_r.switch_time_one;
    job_nxt.t2     = seg_r.switch_time_two;
    job_nxt.dur    = seg_r.duration;
    job_nxt.u1     = (seg_r.profile_case == PCASE_ACD) ? u_acc : u_dec;
    job_nxt.u3     = (seg_r.profile_case == PCASE_ACD) ? u_dec : u_acc;
    job_nxt.vconst = (seg_r.duration == '0) ? '0 : vsat;
    job_nxt.dt     = gt_tol_r ? {1'b0, dt_quo} : '0;
    job_nxt.offset = seg_r.time_offset;
    job_nxt.n      = n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      ib_valid_r <= 1'b0;
    end else begin
      if (push && !full) begin
        ib_valid_r <= 1'b1;
      end
      unique case (state_r)
        F_IDLE: begin
          if (ib_valid_r) begin
            ib_valid_r <= 1'b0;
            state_r    <= F_START;
          end
        end
        F_START: begin
          state_r <= fail_now ? F_PUSH : F_DIV;
        end
        F_DIV: begin
          if (dt_done && v_done) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ib_r <= in_data;
    end
    if (state_r == F_IDLE && ib_valid_r) begin
      seg_r <= ib_r;
    end
    if (state_r == F_START) begin
      n_r      <= n_clamp;
      hold_r   <= seg_r.duration < tol_s;
      gt_tol_r <= seg_r.duration > tol_s;
      if (fail_now) begin
        job_r <= '{mode: MODE_FAIL, default: '0};
      end
    end
    if (state_r == F_DIV && dt_done && v_done) begin
      job_r <= job_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bcb_eval.sv @@
`default_nettype none

module bcb_eval import bcb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire bcb_evin_t in_op,
  output logic           out_valid,
  output logic signed [31:0] out_pos,
  output logic signed [31:0] out_vel,
  output bcb_evin_t      out_op
);

  logic               v1_r, v2_r, v3_r, v4_r;
  bcb_evin_t          s1_r, s2_r, s3_r, s4_r;
  logic signed [63:0] ut_r, vt_r;
  logic signed [63:0] utq_r, vtq_r;
  logic signed [31:0] sat_ut_r;
  logic signed [63:0] utq3_r, vtq3_r, h_r;
  logic signed [31:0] pos_r, vel_r;
  logic signed [63:0] ut_q;
  logic signed [63:0] half;

  assign ut_q = ut_r >>> FRAC_BITS;
  assign half = h_r >>> (FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    // u*t and v*t
    s1_r     <= in_op;
    ut_r     <= 64'(in_op.u) * 64'(in_op.tau);
    vt_r     <= 64'(in_op.vb) * 64'(in_op.tau);
    // scale back, saturate u*t for the half term
    s2_r     <= s1_r;
    utq_r    <= ut_q;
    vtq_r    <= vt_r >>> FRAC_BITS;
    sat_ut_r <= sat32(ut_q);
    // sat(u*t) * t
    s3_r     <= s2_r;
    utq3_r   <= utq_r;
    vtq3_r   <= vtq_r;
    h_r      <= 64'(sat_ut_r) * 64'(s2_r.tau);
    // sum and saturate
    s4_r     <= s3_r;
    pos_r    <= sat32(64'(s3_r.pb) + vtq3_r + half);
    vel_r    <= sat32(64'(s3_r.vb) + utq3_r);
  end

  assign out_valid = v4_r;
  assign out_pos   = pos_r;
  assign out_vel   = vel_r;
  assign out_op    = s4_r;

endmodule

`default_nettype wire

@@ hdl/bcb_back.sv @@
`default_nettype none

module bcb_back import bcb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     job_valid,
  input  wire bcb_job_t job_in,
  output logic          job_pop,
  output logic          out_push,
  output bcb_out_t      out_data,
  input  wire logic     out_taken
);

  localparam int CRW = $clog2(OUT_DEPTH + 1);

  typedef enum logic [2:0] {B_IDLE, B_PRE1, B_WAIT1, B_PRE2, B_WAIT2, B_RUN} bstate_t;

  bstate_t            state_r;
  bcb_job_t           job_r;
  logic [CNT_W-1:0]   k_r;
  logic [31:0]        tacc_r;
  logic signed [31:0] p1_r, v1_r, p2_r;
  logic [CRW-1:0]     credits_r;
  logic               iss_valid_r;
  bcb_evin_t          iss_r;

  logic               ev_valid;
  logic signed [31:0] ev_pos, ev_vel;
  bcb_evin_t          ev_op;

  logic               last_now;
  logic signed [31:0] t_now;
  logic signed [31:0] t1s, t2s;
  logic               issue_smp;
  bcb_evin_t          smp;
  bcb_evin_t          pre1_op;
  bcb_evin_t          pre2_op;

  assign job_pop   = (state_r == B_IDLE) && job_valid;
  assign last_now  = (job_r.mode == MODE_FAIL) || (k_r == job_r.n - CNT_W'(1));
  assign t_now     = last_now ? job_r.dur : $signed(tacc_r);
  assign t1s       = $signed({1'b0, job_r.t1});
  assign t2s       = $signed({1'b0, job_r.t2});
  assign issue_smp = (state_r == B_RUN) && (credits_r != '0);

  // Setup passes: state at the first switch, then position at the second.
  always_comb begin
    pre1_op           = '0;
    pre1_op.pb        = job_r.p0;
    pre1_op.vb        = job_r.v0;
    pre1_op.u         = job_r.u1;
    pre1_op.tau       = t1s;
    pre1_op.meta.kind = K_PRE1;
    pre2_op           = '0;
    pre2_op.pb        = p1_r;
    pre2_op.vb        = v1_r;
    pre2_op.tau       = t2s - t1s;
    pre2_op.meta.kind = K_PRE2;
  end

  always_comb begin
    smp             = '0;
    smp.meta.kind   = K_SAMPLE;
    smp.meta.stime  = job_r.offset + 32'(t_now);
    smp.meta.last   = last_now;
    unique case (job_r.mode)
      MODE_FAIL: begin
        smp.meta.stime  = '0;
        smp.meta.failed = 1'b1;
      end
      MODE_HOLD: begin
        smp.pb = job_r.p0;
        smp.vb = job_r.v0;
      end
      MODE_CONST: begin
        smp.pb  = job_r.p0;
        smp.vb  = job_r.vconst;
        smp.tau = t_now;
      end
      MODE_PROFILE: begin
        priority if (t_now < t1s) begin
          smp.pb  = job_r.p0;
          smp.vb  = job_r.v0;
          smp.u   = job_r.u1;
          smp.tau = t_now;
        end else if (t_now < t2s) begin
          smp.pb  = p1_r;
          smp.vb  = v1_r;
          smp.tau = t_now - t1s;
        end else begin
          smp.pb  = p2_r;
          smp.vb  = v1_r;
          smp.u   = job_r.u3;
          smp.tau = t_now - t2s;
        end
      end
      default: smp = '0;
    endcase
  end

  bcb_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (iss_valid_r),
    .in_op     (iss_r),
    .out_valid (ev_valid),
    .out_pos   (ev_pos),
    .out_vel   (ev_vel),
    .out_op    (ev_op)
  );

  assign out_push = ev_valid && (ev_op.meta.kind == K_SAMPLE);

  always_comb begin
    out_data = '0;
    out_data.failed = ev_op.meta.failed;
    out_data.last   = ev_op.meta.last;
    if (!ev_op.meta.failed) begin
      out_data.sample_time  = ev_op.meta.stime;
      out_data.position     = ev_pos;
      out_data.velocity     = ev_vel;
      out_data.acceleration = ev_op.u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      credits_r   <= CRW'(OUT_DEPTH);
      iss_valid_r <= 1'b0;
    end else begin
      iss_valid_r <= 1'b0;
      if (issue_smp && !out_taken) begin
        credits_r <= credits_r - 1'b1;
      end else if (!issue_smp && out_taken) begin
        credits_r <= credits_r + 1'b1;
      end
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            state_r <= (job_in.mode == MODE_PROFILE) ? B_PRE1 : B_RUN;
          end
        end
        B_PRE1: begin
          iss_valid_r <= 1'b1;
          state_r     <= B_WAIT1;
        end
        B_WAIT1: begin
          if (ev_valid && ev_op.meta.kind == K_PRE1) begin
            state_r <= B_PRE2;
          end
        end
        B_PRE2: begin
          iss_valid_r <= 1'b1;
          state_r     <= B_WAIT2;
        end
        B_WAIT2: begin
          if (ev_valid && ev_op.meta.kind == K_PRE2) begin
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          if (issue_smp) begin
            iss_valid_r <= 1'b1;
            if (last_now) begin
              state_r <= B_IDLE;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r  <= job_in;
      k_r    <= '0;
      tacc_r <= '0;
    end
    if (state_r == B_PRE1) begin
      iss_r <= pre1_op;
    end
    if (state_r == B_WAIT1 && ev_valid && ev_op.meta.kind == K_PRE1) begin
      p1_r <= ev_pos;
      v1_r <= ev_vel;
    end
    if (state_r == B_PRE2) begin
      iss_r <= pre2_op;
    end
    if (state_r == B_WAIT2 && ev_valid && ev_op.meta.kind == K_PRE2) begin
      p2_r <= ev_pos;
    end
    if (issue_smp) begin
      iss_r  <= smp;
      k_r    <= k_r + 1'b1;
      tacc_r <= tacc_r + job_r.dt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bang_coast_bang_profile_sampler.sv @@
// Flow: input buffer, a bit-serial divide, job queue, then two setup passes for the
//   profile cases before the first sample; hold and constant skip the setup passes, and
//   a failure skips the divide.
// Throughput: one sample per cycle once running, while the back end holds result-queue
//   credits; the front end works on the next segment while the back end streams samples,
//   overlapped. Reset: synchronous, active low; clears queues and control, loads
//   sample_count 20 and time_tolerance 66.
`default_nettype none

module bang_coast_bang_profile_sampler import bcb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input queue side
  input  wire logic        push,
  input  wire bcb_in_t     in_data,
  output logic             full,
  // result queue side
  output logic             empty,
  input  wire logic        pop,
  output bcb_out_t         out_data,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CNT_W-1:0] sample_count_r;
  logic [TOL_W-1:0] time_tol_r;
  logic             cfg_wr;

  logic             job_push;
  bcb_job_t         job_wdata;
  logic             job_full;
  logic             job_empty;
  logic             job_pop;
  logic [$bits(bcb_job_t)-1:0] job_rdata;

  logic             ofifo_push;
  bcb_out_t         ofifo_wdata;
  logic             ofifo_full;
  logic [$bits(bcb_out_t)-1:0] ofifo_rdata;
  logic             out_taken;

  // Registers: sample count at 0, time tolerance at 4. Written in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CNT_W'(20);
      time_tol_r     <= TOL_W'(66);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SAMPLE_COUNT: sample_count_r <= pwdata[CNT_W-1:0];
        REG_TIME_TOL:     time_tol_r     <= pwdata[TOL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SAMPLE_COUNT: prdata = {{(32 - CNT_W){1'b0}}, sample_count_r};
      REG_TIME_TOL:     prdata = {{(32 - TOL_W){1'b0}}, time_tol_r};
    endcase
  end

  // Front end: buffer the segment, classify it, run the divides.
  bcb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_data      (in_data),
    .full         (full),
    .sample_count (sample_count_r),
    .time_tol     (time_tol_r),
    .job_push     (job_push),
    .job_data     (job_wdata),
    .job_full     (job_full)
  );

  // Short job queue lets the next divide proceed while samples stream out.
  bcb_fifo #(.WIDTH($bits(bcb_job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wdata),
    .rd_en   (job_pop),
    .rd_data (job_rdata),
    .full    (job_full),
    .empty   (job_empty)
  );

  // Back end: setup passes for the switch points in profile mode, then one sample per cycle while it holds credits.
  bcb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job_in    (bcb_job_t'(job_rdata)),
    .job_pop   (job_pop),
    .out_push  (ofifo_push),
    .out_data  (ofifo_wdata),
    .out_taken (out_taken)
  );

  // Result queue; the back end holds credits for every free entry.
  assign out_taken = pop && !empty;

  bcb_fifo #(.WIDTH($bits(bcb_out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ofifo_push),
    .wr_data (ofifo_wdata),
    .rd_en   (pop),
    .rd_data (ofifo_rdata),
    .full    (ofifo_full),
    .empty   (empty)
  );

  assign out_data = bcb_out_t'(ofifo_rdata);

  // Credit accounting must keep the result queue from overflowing.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(ofifo_push && ofifo_full))
    else $error("result queue written while full");

  a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && job_full))
    else $error("job queue written while full");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full)
    else $error("input buffer not held after transfer");

endmodule

`default_nettype wire

@@ tb/sv/bang_coast_bang_profile_sampler_test.sv @@
`timescale 1ns / 100ps

// Segment sampler bench: segments go in through the push/full queue, samples come
// out through empty/pop and are compared field by field against an in-bench
// fixed-point evaluation of the same profile.
module bang_coast_bang_profile_sampler_test;
  import bcb_pkg::*;

  // Predict the samples of a segment and keep them in arrival order.
  class sample_scoreboard;
    bcb_out_t pending[$];
    int unsigned   n_cfg;
    longint        tol_cfg;
    int unsigned   errors;
    int unsigned   checked;

    function new();
      n_cfg = 20;
      tol_cfg = 66;
      errors = 0;
      checked = 0;
    endfunction

    static function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Floor of x / 2^s, rounding toward minus infinity.
    static function longint fl_shift(longint x, int s);
      return x >>> s;
    endfunction

    static function longint qmul(longint a, longint b);
      return fl_shift(a * b, FRAC_BITS_DEF);
    endfunction

    static function longint qhalf(longint u, longint t);
      return fl_shift(clip32(qmul(u, t)) * t, FRAC_BITS_DEF + 1);
    endfunction

    // Append one expected sample at the tail.
    function void queue_expected(bcb_out_t r);
      pending = {pending, r};
    endfunction

    function void kinematics(bcb_in_t s, longint t,
                             output longint pos, output longint vel,
                             output longint acc);
      longint p0, v0, pt, t1, t2, dur, u1, u3, v1, p1, p2, d, v;
      p0 = longint'(s.start_pos);
      v0 = longint'(s.start_vel);
      pt = longint'(s.end_pos);
      t1 = longint'({1'b0, s.switch_time_one});
      t2 = longint'({1'b0, s.switch_time_two});
      dur = longint'(s.duration);
      if (dur < tol_cfg) begin
        pos = p0; vel = v0; acc = 0;
        return;
      end
      if (s.profile_case == PCASE_CONST) begin
        v = 0;
        if (dur > 0) v = clip32(((pt - p0) * (64'sd1 << FRAC_BITS_DEF)) / dur);
        acc = 0; vel = v; pos = clip32(p0 + qmul(v, t));
        return;
      end
      if (s.profile_case == PCASE_ACD) begin
        u1 = longint'({1'b0, s.accel_limit});
        u3 = -longint'({1'b0, s.decel_limit});
      end else begin
        u1 = -longint'({1'b0, s.decel_limit});
        u3 = longint'({1'b0, s.accel_limit});
      end
      if (t < t1) begin
        acc = u1;
        vel = clip32(v0 + qmul(u1, t));
        pos = clip32(p0 + qmul(v0, t) + qhalf(u1, t));
        return;
      end
      v1 = clip32(v0 + qmul(u1, t1));
      p1 = clip32(p0 + qmul(v0, t1) + qhalf(u1, t1));
      if (t < t2) begin
        acc = 0; vel = v1; pos = clip32(p1 + qmul(v1, t - t1));
        return;
      end
      p2 = clip32(p1 + qmul(v1, t2 - t1));
      d = t - t2;
      if (d < 0) d = 0;
      acc = u3;
      vel = clip32(v1 + qmul(u3, d));
      pos = clip32(p2 + qmul(v1, d) + qhalf(u3, d));
    endfunction

    // Note an accepted segment: expand it into its expected samples.
    function void note_segment(bcb_in_t s);
      int unsigned n;
      longint dur, dt, t, pos, vel, acc;
      bcb_out_t r;
      n = (n_cfg > MAX_SAMPLES) ? MAX_SAMPLES : n_cfg;
      dur = longint'(s.duration);
      if (n < 2 || dur < 0) begin
        r = '0;
        r.failed = 1'b1;
        r.last = 1'b1;
        queue_expected(r);
        return;
      end
      dt = (dur > tol_cfg) ? dur / longint'(n - 1) : 0;
      for (int unsigned k = 0; k < n; k++) begin
        t = (k == n - 1) ? dur : longint'(k) * dt;
        kinematics(s, t, pos, vel, acc);
        r.sample_time = s.time_offset + t[31:0];
        r.position = pos[31:0];
        r.velocity = vel[31:0];
        r.acceleration = acc[31:0];
        r.failed = 1'b0;
        r.last = (k == n - 1);
        queue_expected(r);
      end
    endfunction

    function void check_sample(bcb_out_t got);
      bcb_out_t exp_s;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected sample %h", got);
        return;
      end
      exp_s = pending.pop_front();
      if (got !== exp_s) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: sample %0d exp t=%h p=%h v=%h a=%h f=%b l=%b",
                   checked, exp_s.sample_time, exp_s.position, exp_s.velocity,
                   exp_s.acceleration, exp_s.failed, exp_s.last);
          $display("       got t=%h p=%h v=%h a=%h f=%b l=%b",
                   got.sample_time, got.position, got.velocity, got.acceleration,
                   got.failed, got.last);
        end
      end
    endfunction
  endclass

  localparam logic [2:0] ADDR_SAMPLE_COUNT = {REG_SAMPLE_COUNT, 2'b00};
  localparam logic [2:0] ADDR_TIME_TOL     = {REG_TIME_TOL, 2'b00};
  localparam longint     CYCLE_LIMIT       = 2_000_000;
  localparam int         DRAIN_CYCLES      = 200;

  logic        clk;
  logic        rst_n;
  logic        push;
  bcb_in_t     in_data;
  logic        full;
  logic        empty;
  logic        pop;
  bcb_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sample_scoreboard sb;
  longint      cycle_count;
  bit          sink_idle_on;    // random pop stalls enabled
  int unsigned segments_sent;

  bang_coast_bang_profile_sampler DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .in_data(in_data), .full(full),
    .empty(empty), .pop(pop), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive all inputs to known values before the first edge.
  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    pop = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
  end

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end
  initial cycle_count = 0;

  // Result side: sample each transfer at the edge, then pick the next pop level.
  // Stall pop in random bursts while idling is enabled.
  int unsigned stall_left;
  initial stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_sample(out_data);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop push, wait for every expected sample, then give the back end time to settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned count, input int unsigned tol);
    drain();
    reg_write(ADDR_SAMPLE_COUNT, count);
    reg_write(ADDR_TIME_TOL, tol);
    sb.n_cfg = count & 7'h7F;
    sb.tol_cfg = tol & 16'hFFFF;
  endtask

  // Push one segment; hold push until the transfer, with optional idle gaps first.
  task automatic send_segment(input bcb_in_t s, input bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_segment(s);
    segments_sent++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Well-formed segment with modest magnitudes so the profile phases all show up.
  function automatic bcb_in_t sane_segment();
    bcb_in_t s;
    logic [31:0] dur, a, b;
    dur = $urandom_range(0, 32'h0008_0000);
    a = $urandom_range(0, dur);
    b = $urandom_range(0, dur);
    s.start_pos = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    s.start_vel = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    s.end_pos = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    s.switch_time_one = ($urandom_range(0, 9) == 0) ? b[30:0]
                      : ((a < b) ? a[30:0] : b[30:0]);
    s.switch_time_two = ($urandom_range(0, 9) == 0) ? a[30:0]
                      : ((a < b) ? b[30:0] : a[30:0]);
    s.duration = ($urandom_range(0, 19) == 0) ? -$signed(32'($urandom_range(1, 1000)))
                                              : $signed(dur);
    s.profile_case = 2'($urandom_range(0, 3));
    s.accel_limit = 31'($urandom_range(0, 32'h0008_0000));
    s.decel_limit = 31'($urandom_range(0, 32'h0008_0000));
    s.time_offset = $urandom();
    return s;
  endfunction

  function automatic bcb_in_t noise_segment();
    bcb_in_t s;
    s.start_pos = rand_word();
    s.start_vel = rand_word();
    s.end_pos = rand_word();
    s.switch_time_one = 31'(rand_word());
    s.switch_time_two = 31'(rand_word());
    s.duration = rand_word();
    s.profile_case = 2'($urandom_range(0, 3));
    s.accel_limit = 31'(rand_word());
    s.decel_limit = 31'(rand_word());
    s.time_offset = rand_word();
    return s;
  endfunction

  initial begin
    bcb_in_t s;
    int unsigned n_rand;
    sb = new();
    sink_idle_on = 1'b1;
    segments_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small sample count keeps the extreme segments short.
    set_config(4, 66);
    s = sane_segment();
    s.duration = 32'sh0004_0000;
    s.switch_time_one = 31'h0001_0000;
    s.switch_time_two = 31'h0003_0000;
    for (int pc = 0; pc < 4; pc++) begin
      s.profile_case = 2'(pc);
      send_segment(s, 1'b0);
    end
    s.duration = -32'sd1;                 // negative duration fails
    send_segment(s, 1'b0);
    s.duration = 32'sh8000_0000;
    send_segment(s, 1'b0);
    s.duration = 32'sd10;                 // below tolerance holds start
    send_segment(s, 1'b0);
    s.duration = 32'sd66;                 // equal to tolerance
    send_segment(s, 1'b0);
    s.profile_case = PCASE_ACD;
    s.switch_time_one = 31'h0003_0000;    // second switch before first
    s.switch_time_two = 31'h0001_0000;
    s.duration = 32'sh0004_0000;
    send_segment(s, 1'b0);
    // All-ones and all-zeros fields, saturation everywhere.
    s = '1;
    s.duration = 32'sh7FFF_FFFF;
    s.profile_case = PCASE_ACD;
    send_segment(s, 1'b0);
    s.profile_case = PCASE_DCA;
    s.start_pos = 32'sh8000_0000;
    s.start_vel = 32'sh8000_0000;
    send_segment(s, 1'b0);
    s.profile_case = PCASE_CONST;
    s.end_pos = 32'sh7FFF_FFFF;
    send_segment(s, 1'b0);
    s = '0;
    s.profile_case = PCASE_CONST;
    send_segment(s, 1'b0);
    // Zero tolerance makes a zero-length constant segment evaluate normally.
    set_config(2, 0);
    send_segment(s, 1'b0);
    s.duration = 32'sd1;
    send_segment(s, 1'b0);
    // Counts below two fail; above the maximum clamp.
    set_config(1, 65535);
    send_segment(sane_segment(), 1'b0);
    set_config(0, 65535);
    send_segment(sane_segment(), 1'b0);
    set_config(127, 100);
    send_segment(sane_segment(), 1'b0);
    set_config(64, 66);
    send_segment(noise_segment(), 1'b0);

    // Random phases across several settings; sender pauses for a full drain.
    n_rand = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(20, 66);
        1: set_config(2, 0);
        2: set_config($urandom_range(2, 12), $urandom_range(0, 65535));
        3: set_config(64, 1000);
        4: set_config($urandom_range(0, 127), $urandom_range(0, 300));
        default: set_config($urandom_range(2, 8), 66);
      endcase
      if (ph == 5) sink_idle_on = 1'b0;   // final stretch without idling
      for (int i = 0; i < ((ph == 3) ? 15 : 73); i++) begin
        send_segment(($urandom_range(0, 4) == 0) ? noise_segment() : sane_segment(),
                     ph != 5);
        n_rand++;
      end
    end
    drain();
    $display("Covered %0d segments (%0d random), %0d samples checked, ",
             segments_sent, n_rand, sb.checked);
    $display("all profile cases, hold, failure and count clamping across 7+ settings.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d samples missing", sb.errors, sb.pending.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
